/* sv/kwdm_pkg.sv */
// Shared types and codes for the descending k-way merge.
package kwdm_pkg;

    // Result kinds carried on the output channel
    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_END    = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // Request commands
    localparam logic CMD_SUPPLY = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Control sequence of the merge engine
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

/* sv/kwdm_if.sv */
// Request and result channel interfaces of the descending k-way merge.
interface kwdm_in_if #(
    parameter int IDX_W      = 5,
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [IDX_W-1:0]      list_index;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output list_index, output value, input ready);
    modport sink   (input valid, input cmd, input list_index, input value, output ready);
endinterface

interface kwdm_out_if #(
    parameter int IDX_W      = 5,
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [VALUE_BITS-1:0] merged_value;
    logic [IDX_W-1:0]      refill_list;

    modport source (output valid, output kind, output merged_value, output refill_list,
                    input ready);
    modport sink   (input valid, input kind, input merged_value, input refill_list,
                    output ready);
endinterface

/* sv/k_way_descending_merge.sv */
// Top level of the descending k-way merge engine.
//
// Merges up to MAX_LISTS descending, zero-terminated lists into one descending
// stream, duplicates kept. Each request on i_in either clears the merge (cmd
// set, no result) or supplies the next element of one list into that list's
// head slot. Once every active list (i_cfg_data, clamped to 2..MAX_LISTS) holds
// a head, the engine sweeps the head store and returns the largest head with
// its list number on o_out; that slot is then empty until the list supplies
// again. A head of 0 marks an exhausted list. When the largest head is 0 the
// engine returns an end marker and rejects every supply until a clear. Ties go
// to the lowest list number. A supply to a list outside the active count, to a
// slot already holding a head, or after the end marker gives a reject result.
// A clear, a reject or a supply that leaves some slot empty needs no sweep.
// A supply that fills the last empty slot starts a sweep of the head store
// through its single read port, one slot a cycle; the engine then passes
// through ST_DRAIN to ST_EMIT, which waits for a free output register. No
// request is taken until the engine is idle again. A request is taken while an
// earlier result still waits in the output register, provided that register
// is being emptied or is free. Write configuration only while the engine is idle.
module k_way_descending_merge import kwdm_pkg::*; #(
    parameter  int MAX_LISTS  = 32,
    parameter  int VALUE_BITS = 31,
    localparam int IDX_W      = $clog2(MAX_LISTS),
    localparam int CNT_W      = $clog2(MAX_LISTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    kwdm_in_if.sink          i_in,
    kwdm_out_if.source       o_out
);

    // Configuration and merge state
    logic [CNT_W-1:0]      r_active;
    logic [MAX_LISTS-1:0]  r_present, n_present;
    logic                  r_finished, n_finished;
    t_state                r_state, n_state;

    // Sweep pipeline
    logic [IDX_W-1:0]      r_scan_idx, n_scan_idx;
    logic                  r_q_valid;
    logic [IDX_W-1:0]      r_q_idx;
    logic [VALUE_BITS-1:0] r_best_val, n_best_val;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;

    // Output register
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_out_kind, n_out_kind;
    logic [VALUE_BITS-1:0] r_out_val, n_out_val;
    logic [IDX_W-1:0]      r_out_idx, n_out_idx;

    // Request decode
    logic [CNT_W-1:0]      eff_n;
    logic [IDX_W-1:0]      last_idx;
    logic [MAX_LISTS-1:0]  lane_mask;
    logic [MAX_LISTS-1:0]  present_after;
    logic                  in_accept, is_clear, in_range, slot_full;
    logic                  supply_ok, supply_rej, all_full, out_free;
    logic [VALUE_BITS-1:0] rd_data;

    // Clamp the list count to the supported range
    always_comb begin
        priority if (r_active < CNT_W'(2)) begin
            eff_n = CNT_W'(2);
        end else if (r_active > CNT_W'(MAX_LISTS)) begin
            eff_n = CNT_W'(MAX_LISTS);
        end else begin
            eff_n = r_active;
        end
    end

    assign last_idx = IDX_W'(eff_n - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < MAX_LISTS; i++) begin
            lane_mask[i] = (CNT_W'(i) < eff_n);
        end
    end

    assign out_free     = !r_out_valid || o_out.ready;
    assign i_in.ready   = (r_state == ST_IDLE) && out_free;
    assign in_accept    = i_in.valid && i_in.ready;
    assign is_clear     = (i_in.cmd == CMD_CLEAR);
    assign in_range     = (CNT_W'(i_in.list_index) < eff_n);
    assign slot_full    = in_range && r_present[i_in.list_index];
    assign supply_ok    = in_accept && !is_clear && !r_finished && in_range && !slot_full;
    assign supply_rej   = in_accept && !is_clear && !supply_ok;

    // Fill check includes the slot written by this request
    assign present_after = r_present
                         | (supply_ok ? (MAX_LISTS'(1) << i_in.list_index) : '0);
    assign all_full      = &(present_after | ~lane_mask);

    kwdm_head_mem #(
        .DEPTH (MAX_LISTS),
        .WIDTH (VALUE_BITS),
        .AW    (IDX_W)
    ) u_head_mem (
        .i_clk   (i_clk),
        .i_we    (supply_ok),
        .i_waddr (i_in.list_index),
        .i_wdata (i_in.value),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_scan_idx),
        .o_rdata (rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (supply_ok && all_full) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan_idx == last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_present   = r_present;
        n_finished  = r_finished;
        n_scan_idx  = r_scan_idx;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;
        n_out_idx   = r_out_idx;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Request side: clear, fill or reject
        if (in_accept && is_clear) begin
            n_present  = '0;
            n_finished = 1'b0;
        end
        if (supply_ok) begin
            n_present = present_after;
        end
        if (supply_rej) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_REJECT;
            n_out_val   = '0;
            n_out_idx   = '0;
        end

        // Advance the read address through the active slots
        if (r_state == ST_SCAN) begin
            n_scan_idx = r_scan_idx + IDX_W'(1);
        end else begin
            n_scan_idx = '0;
        end

        // Keep the first strictly larger head, so the lowest list wins ties
        if (r_q_valid && ((r_q_idx == '0) || (rd_data > r_best_val))) begin
            n_best_val = rd_data;
            n_best_idx = r_q_idx;
        end

        if ((r_state == ST_EMIT) && out_free) begin
            n_out_valid = 1'b1;
            if (r_best_val == '0) begin
                n_finished = 1'b1;
                n_out_kind = KIND_END;
                n_out_val  = '0;
                n_out_idx  = '0;
            end else begin
                n_present[r_best_idx] = 1'b0;
                n_out_kind = KIND_VALUE;
                n_out_val  = r_best_val;
                n_out_idx  = r_best_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CNT_W'(MAX_LISTS);
            r_present   <= '0;
            r_finished  <= 1'b0;
            r_state     <= ST_IDLE;
            r_scan_idx  <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            r_present   <= n_present;
            r_finished  <= n_finished;
            r_state     <= n_state;
            r_scan_idx  <= n_scan_idx;
            r_q_valid   <= (r_state == ST_SCAN);
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_q_idx    <= r_scan_idx;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_out_kind <= n_out_kind;
        r_out_val  <= n_out_val;
        r_out_idx  <= n_out_idx;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.merged_value = r_out_val;
    assign o_out.refill_list  = r_out_idx;

endmodule

/* sv/kwdm_head_mem.sv */
// Head slot store: one write port, one read port with registered read data.
module kwdm_head_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 31,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
